// ----- rtl/core/lpps_pkg.sv -----
package lpps_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_SORT   = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic load;     // write wdata into the cell whose index equals count
        logic rotate;   // every cell takes its right neighbour, ring closed at the ends
        logic sort_en;  // odd-even compare-exchange step
        logic phase;    // pairs start at even (0) or odd (1) cells
    } cell_ctl_t;

endpackage

// ----- rtl/core/list_push_pop_search_sort.sv -----
// Channel | Dir | Fields (lowest bit first)                                  | Accept
// --------+-----+------------------------------------------------------------+----------------
// s_*     | in  | tdata: command[2:0], value[34:3], zero pad to 40           | tvalid & tready
// m_*     | out | data_out[31:0], found[32], status[34:33], pad; tlast: last | tvalid & tready
//
// Append, remove, unused codes and any request on an empty list complete on acceptance:
// the result sits in the output register after the accepting edge.
// Search and read out rotate the ring of DEPTH cells once (read out also waits on
// every output stall); sort runs DEPTH odd-even phases, one a cycle.
// A request is taken only with the engine idle and the output register free or
// draining. Reset clears the entry count and control; cells are undefined until written.
module list_push_pop_search_sort #(
    parameter int DEPTH = lpps_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lpps_pkg::S_DATA_W-1:0]  s_tdata,   // command, value, pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lpps_pkg::M_DATA_W-1:0]  m_tdata,   // data_out, found, status, pad
    output logic                           m_tlast
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_SORT = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic                        read_reg, read_next;     // walk is read out, else search
    logic                        hit_reg, hit_next;
    logic                        phase_reg, phase_next;
    logic [lpps_pkg::VAL_W-1:0]  key_reg, key_next;

    logic                        ovalid_reg, ovalid_next;
    logic [lpps_pkg::VAL_W-1:0]  odata_reg, odata_next;
    logic                        ofound_reg, ofound_next;
    lpps_pkg::status_t           ostat_reg, ostat_next;
    logic                        olast_reg, olast_next;

    lpps_pkg::cell_ctl_t         ctl;
    lpps_pkg::cmd_t              cmd;
    logic [lpps_pkg::VAL_W-1:0]  in_value;
    logic [lpps_pkg::VAL_W-1:0]  cell_val [DEPTH];
    logic                        adv;
    logic                        take;
    logic                        in_range;
    logic                        hit_now;

    assign cmd      = lpps_pkg::cmd_t'(s_tdata[lpps_pkg::CMD_W-1:0]);
    assign in_value = s_tdata[lpps_pkg::CMD_W +: lpps_pkg::VAL_W];

    // Output register is free, or its result leaves this cycle
    assign adv      = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && adv;
    assign take     = s_tvalid && s_tready;
    assign in_range = CW'(idx_reg) < count_reg;
    assign hit_now  = in_range && (cell_val[0] == key_reg);

    // Chain of cells: cell i rotates from cell i+1, the last from cell 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        lpps_cell #(
            .DEPTH (DEPTH),
            .IDX   (g),
            .CW    (CW)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .count (count_reg),
            .wdata (in_value),
            .left  (cell_val[(g + DEPTH - 1) % DEPTH]),
            .right (cell_val[(g + 1) % DEPTH]),
            .value (cell_val[g])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        read_next   = read_reg;
        hit_next    = hit_reg;
        phase_next  = phase_reg;
        key_next    = key_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        ofound_next = ofound_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        ctl         = '0;
        ctl.phase   = phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    // default: single final result, status done
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    ofound_next = 1'b0;
                    ostat_next  = lpps_pkg::ST_DONE;
                    olast_next  = 1'b1;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    phase_next  = 1'b0;
                    key_next    = in_value;
                    case (cmd)
                        lpps_pkg::CMD_APPEND:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                ostat_next = lpps_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.load   = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        lpps_pkg::CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                ostat_next = lpps_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        lpps_pkg::CMD_SEARCH, lpps_pkg::CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                ostat_next = lpps_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // hold the result back until the walk produces it
                                ovalid_next = 1'b0;
                                read_next   = cmd == lpps_pkg::CMD_READ;
                                state_next  = S_WALK;
                            end
                        end
                        lpps_pkg::CMD_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                ostat_next = lpps_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ovalid_next = 1'b0;
                                state_next  = S_SORT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (adv)
                begin
                    ctl.rotate  = 1'b1;
                    idx_next    = idx_reg + IW'(1);
                    ofound_next = 1'b0;
                    ostat_next  = lpps_pkg::ST_DONE;
                    if (read_reg)
                    begin
                        // emit the head entry while it is inside the list
                        ovalid_next = in_range;
                        odata_next  = cell_val[0];
                        olast_next  = CW'(idx_reg) + CW'(1) == count_reg;
                    end
                    else
                    begin
                        hit_next = hit_reg || hit_now;
                        if (idx_reg == IDX_LAST)
                        begin
                            ovalid_next = 1'b1;
                            odata_next  = '0;
                            ofound_next = hit_reg || hit_now;
                            olast_next  = 1'b1;
                        end
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_SORT:
            begin
                if (adv)
                begin
                    ctl.sort_en = 1'b1;
                    phase_next  = !phase_reg;
                    idx_next    = idx_reg + IW'(1);
                    if (idx_reg == IDX_LAST)
                    begin
                        ovalid_next = 1'b1;
                        odata_next  = '0;
                        ofound_next = 1'b0;
                        ostat_next  = lpps_pkg::ST_DONE;
                        olast_next  = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            read_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            phase_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            read_reg   <= read_next;
            hit_reg    <= hit_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        odata_reg  <= odata_next;
        ofound_reg <= ofound_next;
        ostat_reg  <= ostat_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'b0, ostat_reg, ofound_reg, odata_reg};

endmodule

// ----- rtl/core/lpps_cell.sv -----
module lpps_cell #(
    parameter int DEPTH = lpps_pkg::DEPTH_DEF,
    parameter int IDX   = 0,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                           clk,
    input  lpps_pkg::cell_ctl_t            ctl,
    input  logic [CW-1:0]                  count,
    input  logic [lpps_pkg::VAL_W-1:0]     wdata,
    input  logic [lpps_pkg::VAL_W-1:0]     left,
    input  logic [lpps_pkg::VAL_W-1:0]     right,
    output logic [lpps_pkg::VAL_W-1:0]     value
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic          MY_PAR  = IDX % 2 == 1;
    localparam bit            HAS_LFT = IDX >= 1;

    logic [lpps_pkg::VAL_W-1:0] value_reg;
    logic [lpps_pkg::VAL_W-1:0] value_next;
    logic                       lower;
    logic                       swap_up;
    logic                       swap_dn;

    always_comb
    begin
        lower   = MY_PAR == ctl.phase;
        // lower cell of a pair: keep the smaller, swap only on strictly greater
        swap_up = lower && (32'(IDX) + 32'd1 < 32'(count)) &&
                  ($signed(value_reg) > $signed(right));
        swap_dn = !lower && HAS_LFT && (MY_IDX < count) &&
                  ($signed(left) > $signed(value_reg));
        value_next = value_reg;
        if (ctl.load && count == MY_IDX)
        begin
            value_next = wdata;
        end
        else if (ctl.rotate)
        begin
            value_next = right;
        end
        else if (ctl.sort_en)
        begin
            if (swap_up)
            begin
                value_next = right;
            end
            else if (swap_dn)
            begin
                value_next = left;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- dv/lpps_list_shadow.sv -----
`timescale 1ns / 100ps

// Shadow copy of the list: tracks accepted requests, works out the replies
// they cause and compares them with what leaves the master side.
module lpps_list_shadow
    import lpps_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // command, value, pad
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // data_out, found, status, pad
    input  logic                m_tlast,
    output int                  mismatch_count,
    output int                  replies_outstanding
);

    typedef struct {
        logic signed [VAL_W-1:0] data;
        logic                    found;
        status_t                 status;
        logic                    last;
    } list_reply_t;

    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int                      list_len;
    list_reply_t             replies_due [$];

    initial
    begin
        mismatch_count      = 0;
        replies_outstanding = 0;
        list_len            = 0;
    end

    // Apply one command to the shadow list and queue the replies it causes.
    task automatic step_list(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
        list_reply_t             r;
        logic signed [VAL_W-1:0] held;
        int                      j;
        bit                      streamed;
        r.data   = '0;
        r.found  = 1'b0;
        r.status = ST_DONE;
        r.last   = 1'b1;
        streamed = 1'b0;
        case (cmd)
            CMD_APPEND:
            begin
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    list_vals[list_len] = val;
                    list_len++;
                end
            end
            CMD_REMOVE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    list_len--;
            end
            CMD_SEARCH:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    for (int i = 0; i < list_len; i++)
                        if (list_vals[i] == val)
                            r.found = 1'b1;
            end
            CMD_SORT:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    // stable insertion sort, signed ascending
                    for (int i = 1; i < list_len; i++)
                    begin
                        held = list_vals[i];
                        j    = i;
                        while (j > 0 && list_vals[j-1] > held)
                        begin
                            list_vals[j] = list_vals[j-1];
                            j--;
                        end
                        list_vals[j] = held;
                    end
            end
            CMD_READ:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    streamed = 1'b1;
                    for (int i = 0; i < list_len; i++)
                    begin
                        r.data = list_vals[i];
                        r.last = (i == list_len - 1);
                        replies_due.push_back(r);
                    end
                end
            end
            default: ;
        endcase
        if (!streamed)
            replies_due.push_back(r);
    endtask

    always @(posedge clk)
    begin : sample
        list_reply_t want;
        if (!rst_n)
        begin
            replies_due.delete();
            list_len = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display({"%0t: unexpected reply: expected none, ",
                              "got data %h found %b status %0d last %b"},
                             $time, m_tdata[31:0], m_tdata[32], m_tdata[34:33], m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (m_tdata[31:0] !== want.data)
                    begin
                        $display("%0t: data_out mismatch: expected %h, got %h",
                                 $time, want.data, m_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[32] !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %b, got %b",
                                 $time, want.found, m_tdata[32]);
                        mismatch_count++;
                    end
                    if (m_tdata[34:33] !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_tdata[34:33]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $time, want.last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tdata[M_DATA_W-1:35] !== '0)
                    begin
                        $display("%0t: pad mismatch: expected %h, got %h",
                                 $time, {(M_DATA_W-35){1'b0}}, m_tdata[M_DATA_W-1:35]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                step_list(s_tdata[CMD_W-1:0], s_tdata[CMD_W+VAL_W-1:CMD_W]);
        end
        replies_outstanding = replies_due.size();
    end

endmodule

// ----- dv/list_push_pop_search_sort_tb.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the bounded list engine. Requests go in on the
// slave side, replies are collected on the master side; lpps_list_shadow
// keeps its own copy of the list and does all the checking.
module list_push_pop_search_sort_tb;
    import lpps_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RAND_ITEMS  = 370;
    // Worst case per request is a full read-out with every reply stalled
    // plus the longest sender gap, taken over ~400 requests.
    localparam int CYCLE_LIMIT = 400_000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;    // command[2:0], value[34:3], pad
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // data_out[31:0], found[32], status[34:33], pad
    logic                m_tlast;

    int mismatch_count;
    int replies_outstanding;
    int cycle_count = 0;
    int sent        = 0;

    // Zero-gap stretches on either side, switched per burst of requests
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;

    logic [VAL_W-1:0] last_appended = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    list_push_pop_search_sort #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lpps_list_shadow #(
        .DEPTH (DEPTH)
    ) u_shadow (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tlast             (m_tlast),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    // Hard stop: a hung engine or a lost reply ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Reply side: after each accepted reply drop tready for a drawn number of
    // cycles, otherwise hold it high so back-to-back replies drain at full rate.
    initial
    begin : reply_sink
        int rx_hold;
        rx_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold != 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
                if (m_tvalid)
                    rx_hold = rx_eager ? 0 : $urandom_range(0, 14);
            end
        end
    end

    // Present one request; entered and left on a falling edge. Lower tvalid
    // only when a gap is drawn, so a zero gap keeps it high across requests.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-VAL_W-CMD_W){1'b0}}, val, cmd};
        if (cmd == CMD_APPEND)
            last_appended = val;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent++;
    endtask

    // Value flavours: a narrow band around zero gives duplicates and search
    // hits, the extremes stress signed ordering, the rest is full range.
    function automatic logic [VAL_W-1:0] pick_value(input int flavour);
        case (flavour)
            0: return VAL_W'($signed($urandom_range(0, 7)) - 4);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial
    begin : stimulus
        int flavour;
        int fill;
        int mix;
        int drain;
        logic [CMD_W-1:0] odd_code;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every command on an empty list, the unused codes,
        // a one-entry sort, signed extremes and a duplicate pair.
        send_request(CMD_READ,   '0);
        send_request(CMD_REMOVE, '0);
        send_request(CMD_SEARCH, '0);
        send_request(CMD_SORT,   '0);
        send_request(3'd5, 32'hFFFF_FFFF);
        send_request(3'd6, '0);
        send_request(3'd7, 32'h5A5A_A5A5);
        send_request(CMD_APPEND, 32'h7FFF_FFFF);
        send_request(CMD_SORT,   '0);
        send_request(CMD_READ,   '0);
        send_request(CMD_APPEND, 32'h8000_0000);
        send_request(CMD_APPEND, 32'hFFFF_FFFF);
        send_request(CMD_APPEND, '0);
        send_request(CMD_APPEND, 32'd1);
        send_request(CMD_APPEND, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'd12345);
        send_request(CMD_SORT,   '0);
        send_request(CMD_READ,   '0);
        send_request(CMD_REMOVE, '0);
        send_request(CMD_READ,   '0);

        // Random bursts: fill (often past full), a mixed stretch, a sorted
        // read-back, then drain (sometimes past empty).
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            flavour  = $urandom_range(0, 2);
            fill     = ($urandom_range(0, 3) == 0) ? DEPTH + $urandom_range(1, 4)
                                                   : $urandom_range(0, DEPTH);
            repeat (fill)
                send_request(CMD_APPEND, pick_value(flavour));

            mix = $urandom_range(2, 8);
            repeat (mix)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: send_request(CMD_APPEND, pick_value(flavour));
                    3:       send_request(CMD_REMOVE, $urandom());
                    4:       send_request(CMD_SEARCH, last_appended);
                    5:       send_request(CMD_SEARCH, pick_value(flavour));
                    6:       send_request(CMD_SORT, $urandom());
                    7:       send_request(CMD_READ, $urandom());
                    8:
                    begin
                        odd_code = CMD_W'($urandom_range(5, 7));
                        send_request(odd_code, $urandom());
                    end
                    default: send_request(CMD_APPEND, $urandom());
                endcase
            end

            send_request(CMD_READ, '0);
            send_request(CMD_SORT, '0);
            send_request(CMD_READ, '0);

            drain = $urandom_range(0, DEPTH + 4);
            repeat (drain)
                send_request(CMD_REMOVE, '0);
        end

        s_tvalid <= 1'b0;
        tx_eager = 1'b0;
        rx_eager = 1'b0;

        // Let every queued reply arrive, then keep watching the master side
        // so nothing stray slips out unchecked.
        while (replies_outstanding != 0)
            @(negedge clk);
        repeat (4 * DEPTH) @(negedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
